// ----- hw/rtl/eztq_pkg.sv -----
// ---------------------------------------------------------------------------
// eztq_pkg
// Shared constants, types and the arctangent table for the Euler-to-quaternion
// pipeline. Internal trigonometry runs in Q.30.
// ---------------------------------------------------------------------------
package eztq_pkg;

  localparam int TW       = 34;  // CORDIC lane width, Q.30 with headroom
  localparam int CSW      = 32;  // cosine / sine width handed to the products
  localparam int FRAC     = 30;

  localparam logic signed [TW-1:0] K_Q30       = 34'sd652032874;
  localparam logic signed [TW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [TW-1:0] PI_Q30      = 34'sd3373259426;

  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  function automatic logic signed [TW-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

// ----- hw/rtl/eztq_if.sv -----
// ---------------------------------------------------------------------------
// eztq_angle_if / eztq_quat_if
// Valid/ready channels for the angle triple and the quaternion result.
// ---------------------------------------------------------------------------
interface eztq_angle_if #(parameter int ANGLE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] yaw;
  logic signed [ANGLE_WIDTH-1:0] pitch;
  logic signed [ANGLE_WIDTH-1:0] roll;
  modport source (output valid, yaw, pitch, roll, input ready);
  modport sink   (input valid, yaw, pitch, roll, output ready);
endinterface

interface eztq_quat_if #(parameter int COMPONENT_WIDTH = 16);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] quat_w;
  logic signed [COMPONENT_WIDTH-1:0] quat_x;
  logic signed [COMPONENT_WIDTH-1:0] quat_y;
  logic signed [COMPONENT_WIDTH-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- hw/rtl/euler_zyx_to_quaternion.sv -----
// Path from input transaction to result: fold register, one register per
// CORDIC iteration, then three product/round stages.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// result register is full and not taken.
// Reset: synchronous, clears every valid bit; data registers are not reset.
// ---------------------------------------------------------------------------
// euler_zyx_to_quaternion
// Converts z-y-x Tait-Bryan angles to a saturated fixed-point quaternion.
// ---------------------------------------------------------------------------
module euler_zyx_to_quaternion #(
  parameter int ANGLE_WIDTH     = 16,
  parameter int COMPONENT_WIDTH = 16,
  parameter int TRIG_STEPS      = 16
) (
  input  logic         clk,
  input  logic         rst,
  eztq_angle_if.sink   angles,
  eztq_quat_if.source  quat
);
  import eztq_pkg::*;

  localparam logic signed [COMPONENT_WIDTH-1:0] ONE_C =
    COMPONENT_WIDTH'(64'd1 << (COMPONENT_WIDTH - 2));

  logic                  en;
  logic                  trig_valid;
  logic [2:0][CSW-1:0]   cos_h, sin_h;
  logic [2:0][ANGLE_WIDTH-1:0] angle;

  // advance whenever the result register is free or being taken
  assign en           = !quat.valid || quat.ready;
  assign angles.ready = en;
  assign angle        = {angles.roll, angles.pitch, angles.yaw};

  eztq_half_trig #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .TRIG_STEPS  (TRIG_STEPS)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (angles.valid),
    .angle     (angle),
    .out_valid (trig_valid),
    .cos_h     (cos_h),
    .sin_h     (sin_h)
  );

  eztq_quat #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_quat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (trig_valid),
    .cos_h     (cos_h),
    .sin_h     (sin_h),
    .out_valid (quat.valid),
    .qw        (quat.quat_w),
    .qx        (quat.quat_x),
    .qy        (quat.quat_y),
    .qz        (quat.quat_z)
  );

`ifndef SYNTHESIS
  a_reset_empty : assert property (@(posedge clk) rst |=> !quat.valid)
    else $error("result valid after reset");
  a_w_range : assert property (@(posedge clk) disable iff (rst)
    quat.valid |-> (quat.quat_w <= ONE_C) && (quat.quat_w >= -ONE_C))
    else $error("quat_w beyond saturation bound");
  a_x_range : assert property (@(posedge clk) disable iff (rst)
    quat.valid |-> (quat.quat_x <= ONE_C) && (quat.quat_x >= -ONE_C))
    else $error("quat_x beyond saturation bound");
`endif

endmodule

// ----- hw/rtl/eztq_cordic_stage.sv -----
// ---------------------------------------------------------------------------
// eztq_cordic_stage
// One registered rotation-mode CORDIC iteration over three angle lanes.
// ---------------------------------------------------------------------------
module eztq_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  eztq_pkg::lanes_t d,
  output logic            out_valid,
  output eztq_pkg::lanes_t q
);
  import eztq_pkg::*;

  localparam logic signed [TW-1:0] ATAN_I = atan_q30(5'(STEP));

  lanes_t q_next;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q_next[l].neg = d[l].neg;
      if (!d[l].z[TW-1]) begin
        q_next[l].x = d[l].x - (d[l].y >>> STEP);
        q_next[l].y = d[l].y + (d[l].x >>> STEP);
        q_next[l].z = d[l].z - ATAN_I;
      end else begin
        q_next[l].x = d[l].x + (d[l].y >>> STEP);
        q_next[l].y = d[l].y - (d[l].x >>> STEP);
        q_next[l].z = d[l].z + ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ----- hw/rtl/eztq_half_trig.sv -----
// ---------------------------------------------------------------------------
// eztq_half_trig
// Halves three angles, folds them into the CORDIC range and runs the
// unrolled CORDIC pipeline to give cosine and sine of each half angle.
// ---------------------------------------------------------------------------
module eztq_half_trig #(
  parameter int ANGLE_WIDTH = 16,
  parameter int TRIG_STEPS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][ANGLE_WIDTH-1:0]         angle,
  output logic                                out_valid,
  output logic [2:0][eztq_pkg::CSW-1:0]       cos_h,
  output logic [2:0][eztq_pkg::CSW-1:0]       sin_h
);
  import eztq_pkg::*;

  localparam int SHIFT = 32 - ANGLE_WIDTH;

  lanes_t             fold_next;
  lanes_t             pipe  [TRIG_STEPS+1];
  logic [TRIG_STEPS:0] vpipe;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [TW-1:0] h;
      h = TW'($signed(angle[l])) <<< SHIFT;
      fold_next[l].x   = K_Q30;
      fold_next[l].y   = '0;
      fold_next[l].neg = 1'b0;
      fold_next[l].z   = h;
      if (h > HALF_PI_Q30) begin
        fold_next[l].z   = h - PI_Q30;
        fold_next[l].neg = 1'b1;
      end else if (h < -HALF_PI_Q30) begin
        fold_next[l].z   = h + PI_Q30;
        fold_next[l].neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe[0] <= 1'b0;
    end else if (en) begin
      vpipe[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= fold_next;
    end
  end

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_step
    eztq_cordic_stage #(.STEP(i)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vpipe[i]),
      .d         (pipe[i]),
      .out_valid (vpipe[i+1]),
      .q         (pipe[i+1])
    );
  end

  // undo the fold by negating both results
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (pipe[TRIG_STEPS][l].neg) begin
        cos_h[l] = CSW'(-pipe[TRIG_STEPS][l].x);
        sin_h[l] = CSW'(-pipe[TRIG_STEPS][l].y);
      end else begin
        cos_h[l] = CSW'(pipe[TRIG_STEPS][l].x);
        sin_h[l] = CSW'(pipe[TRIG_STEPS][l].y);
      end
    end
  end

  assign out_valid = vpipe[TRIG_STEPS];

endmodule

// ----- hw/rtl/eztq_quat.sv -----
// ---------------------------------------------------------------------------
// eztq_quat
// Three-stage product pipeline: yaw-pitch pair products, products with roll
// terms, then sums rounded and saturated to the component grid.
// ---------------------------------------------------------------------------
module eztq_quat #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][eztq_pkg::CSW-1:0]         cos_h,
  input  logic [2:0][eztq_pkg::CSW-1:0]         sin_h,
  output logic                                  out_valid,
  output logic signed [COMPONENT_WIDTH-1:0]     qw,
  output logic signed [COMPONENT_WIDTH-1:0]     qx,
  output logic signed [COMPONENT_WIDTH-1:0]     qy,
  output logic signed [COMPONENT_WIDTH-1:0]     qz
);
  import eztq_pkg::*;

  localparam int PW = 2 * CSW;
  localparam int SW = PW + 2;
  localparam int SH = 2 * FRAC - (COMPONENT_WIDTH - 2);
  localparam logic signed [SW-1:0] RND   = SW'(64'd1 << (SH - 1));
  localparam logic signed [SW-1:0] ONE_C = SW'(64'd1 << (COMPONENT_WIDTH - 2));

  logic                  v1, v2;
  logic signed [PW-1:0]  cc, ss, cs, sc;
  logic signed [CSW-1:0] rc1, rs1;
  logic signed [PW-1:0]  m [8];

  function automatic logic signed [COMPONENT_WIDTH-1:0] to_comp(
    input logic signed [SW-1:0] s
  );
    logic signed [SW-1:0] r;
    r = (s + RND) >>> SH;
    if (r > ONE_C) r = ONE_C;
    if (r < -ONE_C) r = -ONE_C;
    return COMPONENT_WIDTH'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc  <= $signed(cos_h[0]) * $signed(cos_h[1]);
      ss  <= $signed(sin_h[0]) * $signed(sin_h[1]);
      cs  <= $signed(cos_h[0]) * $signed(sin_h[1]);
      sc  <= $signed(sin_h[0]) * $signed(cos_h[1]);
      rc1 <= $signed(cos_h[2]);
      rs1 <= $signed(sin_h[2]);
    end
  end

  // floor the pair products to Q.30 and multiply by the roll terms
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= $signed(cc[FRAC+CSW-1:FRAC]) * rc1;
      m[1] <= $signed(ss[FRAC+CSW-1:FRAC]) * rs1;
      m[2] <= $signed(cc[FRAC+CSW-1:FRAC]) * rs1;
      m[3] <= $signed(ss[FRAC+CSW-1:FRAC]) * rc1;
      m[4] <= $signed(cs[FRAC+CSW-1:FRAC]) * rc1;
      m[5] <= $signed(sc[FRAC+CSW-1:FRAC]) * rs1;
      m[6] <= $signed(sc[FRAC+CSW-1:FRAC]) * rc1;
      m[7] <= $signed(cs[FRAC+CSW-1:FRAC]) * rs1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw <= to_comp(SW'(m[0]) + SW'(m[1]));
      qx <= to_comp(SW'(m[2]) - SW'(m[3]));
      qy <= to_comp(SW'(m[4]) + SW'(m[5]));
      qz <= to_comp(SW'(m[6]) - SW'(m[7]));
    end
  end

endmodule

// ----- bench/euler_zyx_to_quaternion_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_zyx_to_quaternion_checker
// Watches the angle and quaternion channels, predicts each quaternion from
// the accepted angles and compares it field by field, in order.
// ---------------------------------------------------------------------------
module euler_zyx_to_quaternion_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [15:0]  yaw,
  input  logic [15:0]  pitch,
  input  logic [15:0]  roll,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [15:0]  quat_w,
  input  logic [15:0]  quat_x,
  input  logic [15:0]  quat_y,
  input  logic [15:0]  quat_z,
  output int           fail_count,
  output int           pending
);

  localparam longint K_FIX       = 64'sd652032874;
  localparam longint HALF_PI_FIX = 64'sd1686629713;
  localparam longint PI_FIX      = 64'sd3373259426;
  localparam int     STEPS       = 16;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } quat_t;

  quat_t expected_quats[$];
  longint atan_tab[16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  // Cosine and sine of half the angle, Q.30
  function automatic void half_cos_sin(input logic signed [15:0] ang, output longint c,
                                       output longint s);
    longint h, x, y, nx;
    bit     flip;
    h = longint'(ang) * 65536;
    x = K_FIX;
    y = 0;
    flip = 0;
    if (h > HALF_PI_FIX) begin
      h -= PI_FIX;
      flip = 1;
    end else if (h < -HALF_PI_FIX) begin
      h += PI_FIX;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (h >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        h -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        h += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] round_sat(input longint q60);
    longint r;
    r = (q60 + (64'sd1 <<< 45)) >>> 46;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic quat_t predict_quat(input logic [15:0] ya, input logic [15:0] pa,
                                         input logic [15:0] ra);
    longint yc, ys, pc, ps, rc, rs, cc, ss, cs, sc;
    quat_t q;
    half_cos_sin(ya, yc, ys);
    half_cos_sin(pa, pc, ps);
    half_cos_sin(ra, rc, rs);
    cc = (yc * pc) >>> 30;
    ss = (ys * ps) >>> 30;
    cs = (yc * ps) >>> 30;
    sc = (ys * pc) >>> 30;
    q.w = round_sat(cc * rc + ss * rs);
    q.x = round_sat(cc * rs - ss * rc);
    q.y = round_sat(cs * rc + sc * rs);
    q.z = round_sat(sc * rc - cs * rs);
    return q;
  endfunction

  assign pending = expected_quats.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    quat_t exp_q, got_q;
    if (!rst) begin
      if (in_valid && in_ready) expected_quats.push_back(predict_quat(yaw, pitch, roll));
      if (out_valid && out_ready) begin
        got_q = '{quat_w, quat_x, quat_y, quat_z};
        if (expected_quats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected quaternion %p", got_q);
        end else begin
          exp_q = expected_quats.pop_front();
          if (exp_q != got_q) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"quaternion mismatch: expected w=%0d x=%0d y=%0d z=%0d, ",
                        "got w=%0d x=%0d y=%0d z=%0d"},
                       $signed(exp_q.w), $signed(exp_q.x), $signed(exp_q.y),
                       $signed(exp_q.z), $signed(got_q.w), $signed(got_q.x),
                       $signed(got_q.y), $signed(got_q.z));
          end
        end
      end
    end
  end

endmodule

// ----- bench/euler_zyx_to_quaternion_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_zyx_to_quaternion_tb
// Drives directed and random angle triples through the converter under
// varying source gaps and sink stalls, including a long sink hold-off.
// ---------------------------------------------------------------------------
module euler_zyx_to_quaternion_tb;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;
  int   send_idle_pct = 0, sink_stall_pct = 0;
  bit   hold_off = 0;

  eztq_angle_if #(.ANGLE_WIDTH(16))     angles ();
  eztq_quat_if  #(.COMPONENT_WIDTH(16)) quat ();

  euler_zyx_to_quaternion uut (.clk(clk), .rst(rst), .angles(angles), .quat(quat));

  euler_zyx_to_quaternion_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(angles.valid), .in_ready(angles.ready),
    .yaw(angles.yaw), .pitch(angles.pitch), .roll(angles.roll),
    .out_valid(quat.valid), .out_ready(quat.ready),
    .quat_w(quat.quat_w), .quat_x(quat.quat_x), .quat_y(quat.quat_y),
    .quat_z(quat.quat_z), .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    angles.valid = 0;
    angles.yaw = 0;
    angles.pitch = 0;
    angles.roll = 0;
    quat.ready = 0;
  end

  // Sink readiness, stalled at random or held low on request
  always @(posedge clk) begin
    quat.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'(32'h8000 + $urandom_range(3) - 1);
      1: return 16'(32'h7FFF - $urandom_range(2));
      // near the fold at plus or minus pi
      2: return 16'((($urandom_range(1) != 0) ? 25736 : -25736)
                    + int'($urandom_range(6)) - 3);
      3: return 16'(int'($urandom_range(16)) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_angles(input logic [15:0] ya, input logic [15:0] pa,
                             input logic [15:0] ra);
    while ($urandom_range(99) < send_idle_pct) begin
      angles.valid <= 0;
      @(posedge clk);
    end
    angles.valid <= 1;
    angles.yaw   <= ya;
    angles.pitch <= pa;
    angles.roll  <= ra;
    do @(posedge clk); while (!angles.ready);
  endtask

  logic [15:0] corner_angles[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                    16'sd12868, -16'sd12868, 16'sd25736};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, fold boundaries, quarter turns
    for (int i = 0; i < 8; i++) send_angles(corner_angles[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) send_angles(16'h0000, corner_angles[i], corner_angles[7 - i]);
    send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h5555, 16'hAAAA, 16'h0F0F);
    send_angles(16'hAAAA, 16'h5555, 16'hF0F0);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 67; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin send_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      for (int n = 0; n < 383; n++) begin
        if (ph == 0 && n == 100) hold_off = 1;
        send_angles(pick_angle(), pick_angle(), pick_angle());
      end
    end
    angles.valid <= 0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hold the sink off long enough for the pipeline to fill and stall the source
  initial begin
    wait (hold_off);
    repeat (80) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
